// ----- design/vcmx_pkg.sv -----
// shared types, codes and constants of the visit-count maze explorer
`timescale 1ns / 1ps

package vcmx_pkg;

	localparam int GRID_SIDE_DEF  = 128;
	localparam int COUNT_BITS_DEF = 16;

	localparam int POS_W      = 7;
	localparam int HEAD_W     = 2;
	localparam int MOTION_W   = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// scoring
	localparam int VISIT_WEIGHT = 5;
	localparam int WALL_PENALTY = 100;
	localparam int BACK_LIMIT   = 100;
	localparam int BACK_PENALTY = 100;
	localparam int BIAS_RIGHT   = 1;
	localparam int BIAS_FRONT   = 2;
	localparam int BIAS_LEFT    = 3;

	localparam logic [MOTION_W-1:0] MOT_FWD   = 3'd0;
	localparam logic [MOTION_W-1:0] MOT_RIGHT = 3'd1;
	localparam logic [MOTION_W-1:0] MOT_LEFT  = 3'd2;
	localparam logic [MOTION_W-1:0] MOT_BACK  = 3'd3;
	localparam logic [MOTION_W-1:0] MOT_NONE  = 3'd4;

	localparam logic [HEAD_W-1:0] HD_N = 2'd0;
	localparam logic [HEAD_W-1:0] HD_E = 2'd1;
	localparam logic [HEAD_W-1:0] HD_S = 2'd2;
	localparam logic [HEAD_W-1:0] HD_W = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_START_X   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_Y   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START_HDG = 2'd2;

	typedef struct packed {
		logic command;
		logic wall_right;
		logic wall_front;
		logic wall_left;
		logic black_tile;
		logic slope_seen;
	} vcmx_in_t;

	typedef struct packed {
		logic [MOTION_W-1:0] motion;
		logic [POS_W-1:0]    pos_x;
		logic [POS_W-1:0]    pos_y;
		logic [HEAD_W-1:0]   heading_out;
	} vcmx_out_t;

	typedef struct packed {
		logic right;
		logic front;
		logic left;
	} vcmx_walls_t;

endpackage

// ----- design/vcmx_count_mem.sv -----
// single-port visit counter memory with registered read data
`timescale 1ns / 1ps

module vcmx_count_mem #(
	parameter int DEPTH = vcmx_pkg::GRID_SIDE_DEF * vcmx_pkg::GRID_SIDE_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int DW    = vcmx_pkg::COUNT_BITS_DEF
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/vcmx_decide.sv -----
// neighbour scoring and motion choice
`timescale 1ns / 1ps

module vcmx_decide #(
	parameter int COUNT_BITS = vcmx_pkg::COUNT_BITS_DEF
) (
	input  logic [COUNT_BITS-1:0]         cnt_r,
	input  logic [COUNT_BITS-1:0]         cnt_f,
	input  logic [COUNT_BITS-1:0]         cnt_l,
	input  vcmx_pkg::vcmx_walls_t         walls,
	output logic [vcmx_pkg::MOTION_W-1:0] motion
);
	import vcmx_pkg::*;

	localparam int SW = COUNT_BITS + 3;

	function automatic logic [SW-1:0] score(input logic [COUNT_BITS-1:0] c,
			input int bias, input logic wall);
		logic [SW-1:0] s;
		s = SW'(c) * SW'(VISIT_WEIGHT) + SW'(bias);
		if (wall) begin
			s = s + SW'(WALL_PENALTY);
		end
		return s;
	endfunction

	logic [SW-1:0] sr, sf, sl, best;

	always_comb begin
		sr = score(cnt_r, BIAS_RIGHT, walls.right);
		sf = score(cnt_f, BIAS_FRONT, walls.front);
		sl = score(cnt_l, BIAS_LEFT, walls.left);
		if (sr <= sf) begin
			motion = MOT_RIGHT;
			best   = sr;
		end else begin
			motion = MOT_FWD;
			best   = sf;
		end
		if (sl < best) begin
			motion = MOT_LEFT;
		end
		if (sr > SW'(BACK_LIMIT) && sf > SW'(BACK_LIMIT) && sl > SW'(BACK_LIMIT)) begin
			motion = MOT_BACK;
		end
	end

endmodule

// ----- design/visit_count_maze_explorer_unit.sv -----
// top level of the visit-count maze explorer: sequencer, position and heading
`timescale 1ns / 1ps

// Usage
// A command word is taken at a rising edge with start high and busy low.
// Every command gives one result word on result, marked by done for one
// cycle; the receiver cannot stall, so results are never held back.
// Tile report: no memory access, done in the cycle after acceptance, busy
// stays low.
// Step: counts of the right, front and left cells are read one per cycle
// from the single-port counter memory, the choice is registered, then the
// destination count is written, and done follows. The next command can
// be taken while done is high. A turn back also updates the current cell
// and reads the back cell. The memory port, one access per cycle, sets
// this order of accesses.
// Reset: position and heading go to zero and the counter memory is cleared
// one entry per cycle, all GRID_SIDE * GRID_SIDE entries (16384 by default),
// with busy high. Start registers are written through cfg_we at any time
// and load position or heading at once.

module visit_count_maze_explorer_unit #(
	parameter int GRID_SIDE  = vcmx_pkg::GRID_SIDE_DEF,
	parameter int COUNT_BITS = vcmx_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  vcmx_pkg::vcmx_in_t               cmd,
	input  logic                             cfg_we,
	input  logic [vcmx_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vcmx_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	output logic                             done,
	output vcmx_pkg::vcmx_out_t              result
);
	import vcmx_pkg::*;

	localparam int CW    = $clog2(GRID_SIDE);
	localparam int DEPTH = GRID_SIDE * GRID_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int NSTART = 1 << CFG_DATA_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_RD_F  = 3'd2;
	localparam logic [2:0] ST_RD_L  = 3'd3;
	localparam logic [2:0] ST_DEC   = 3'd4;
	localparam logic [2:0] ST_UPD   = 3'd5;
	localparam logic [2:0] ST_RD_B  = 3'd6;
	localparam logic [2:0] ST_WR_B  = 3'd7;

	// start value reduced into the grid, one entry per possible write
	function automatic logic [NSTART*CW-1:0] build_mod();
		logic [NSTART*CW-1:0] t;
		int r;
		t = '0;
		r = 0;
		for (int i = 0; i < NSTART; i++) begin
			t[i*CW +: CW] = CW'(r);
			r = (r + 1 == GRID_SIDE) ? 0 : r + 1;
		end
		return t;
	endfunction

	localparam logic [NSTART*CW-1:0] START_MOD = build_mod();

	function automatic logic [CW-1:0] step_x(input logic [CW-1:0] x,
			input logic [HEAD_W-1:0] d);
		logic [CW-1:0] r;
		case (d)
			HD_E:    r = (x == CW'(GRID_SIDE - 1)) ? '0 : x + CW'(1);
			HD_W:    r = (x == '0) ? CW'(GRID_SIDE - 1) : x - CW'(1);
			default: r = x;
		endcase
		return r;
	endfunction

	function automatic logic [CW-1:0] step_y(input logic [CW-1:0] y,
			input logic [HEAD_W-1:0] d);
		logic [CW-1:0] r;
		case (d)
			HD_S:    r = (y == CW'(GRID_SIDE - 1)) ? '0 : y + CW'(1);
			HD_N:    r = (y == '0) ? CW'(GRID_SIDE - 1) : y - CW'(1);
			default: r = y;
		endcase
		return r;
	endfunction

	function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
			input logic [CW-1:0] y);
		return AW'(x) * AW'(GRID_SIDE) + AW'(y);
	endfunction

	function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] c,
			input logic [7:0] amt);
		logic [COUNT_BITS:0] s;
		s = {1'b0, c} + (COUNT_BITS+1)'(amt);
		return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
	endfunction

	logic [2:0]            state_q;
	logic [AW-1:0]         clr_q;
	logic [CW-1:0]         cur_x_q, cur_y_q;
	logic [HEAD_W-1:0]     heading_q;
	vcmx_walls_t           walls_q;
	logic [COUNT_BITS-1:0] cnt_r_q, cnt_f_q, cnt_l_q;
	logic [MOTION_W-1:0]   motion_q;
	logic                  done_q;
	vcmx_out_t             res_q;

	logic                  accept, step_acc, tile_acc;
	logic [HEAD_W-1:0]     hd_r, hd_l, hd_b, hd_dest;
	logic [CW-1:0]         dest_x, dest_y, back_x, back_y, tx1, ty1, tx2, ty2;
	logic [COUNT_BITS-1:0] cnt_dest, rdata, wdata;
	logic [AW-1:0]         addr;
	logic                  mem_we, mem_re;
	logic [MOTION_W-1:0]   motion_d;

	assign accept   = start && !busy;
	assign step_acc = accept && !cmd.command;
	assign tile_acc = accept && cmd.command;
	assign busy     = (state_q != ST_IDLE);

	assign hd_r = heading_q + 2'd1;
	assign hd_l = heading_q + 2'd3;
	assign hd_b = heading_q + 2'd2;

	assign back_x = step_x(cur_x_q, hd_b);
	assign back_y = step_y(cur_y_q, hd_b);

	// tile report: black tile first, then slope
	assign tx1 = cmd.black_tile ? back_x : cur_x_q;
	assign ty1 = cmd.black_tile ? back_y : cur_y_q;
	assign tx2 = cmd.slope_seen ? step_x(tx1, heading_q) : tx1;
	assign ty2 = cmd.slope_seen ? step_y(ty1, heading_q) : ty1;

	always_comb begin
		case (motion_q)
			MOT_RIGHT: begin
				hd_dest  = hd_r;
				cnt_dest = cnt_r_q;
			end
			MOT_LEFT: begin
				hd_dest  = hd_l;
				cnt_dest = cnt_l_q;
			end
			MOT_BACK: begin
				hd_dest  = hd_b;
				cnt_dest = cnt_f_q;
			end
			default: begin
				hd_dest  = heading_q;
				cnt_dest = cnt_f_q;
			end
		endcase
		dest_x = step_x(cur_x_q, hd_dest);
		dest_y = step_y(cur_y_q, hd_dest);
	end

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		addr   = cell_addr(cur_x_q, cur_y_q);
		wdata  = '0;
		unique case (state_q)
			ST_IDLE: begin
				mem_re = step_acc;
				addr   = cell_addr(step_x(cur_x_q, hd_r), step_y(cur_y_q, hd_r));
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				addr   = clr_q;
			end
			ST_RD_F: begin
				mem_re = 1'b1;
				addr   = cell_addr(step_x(cur_x_q, heading_q), step_y(cur_y_q, heading_q));
			end
			ST_RD_L: begin
				mem_re = 1'b1;
				addr   = cell_addr(step_x(cur_x_q, hd_l), step_y(cur_y_q, hd_l));
			end
			ST_DEC: begin
				mem_re = 1'b1;
			end
			ST_UPD: begin
				mem_we = 1'b1;
				if (motion_q == MOT_BACK) begin
					wdata = sat_add(rdata, 8'(BACK_PENALTY));
				end else begin
					addr  = cell_addr(dest_x, dest_y);
					wdata = sat_add(cnt_dest, 8'd1);
				end
			end
			ST_RD_B: begin
				mem_re = 1'b1;
				addr   = cell_addr(back_x, back_y);
			end
			ST_WR_B: begin
				mem_we = 1'b1;
				addr   = cell_addr(back_x, back_y);
				wdata  = sat_add(rdata, 8'd1);
			end
			default: begin
			end
		endcase
	end

	vcmx_count_mem #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (COUNT_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (addr),
		.wdata (wdata),
		.rdata (rdata)
	);

	vcmx_decide #(
		.COUNT_BITS (COUNT_BITS)
	) u_decide (
		.cnt_r  (cnt_r_q),
		.cnt_f  (cnt_f_q),
		.cnt_l  (rdata),
		.walls  (walls_q),
		.motion (motion_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			heading_q <= HD_N;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (step_acc) begin
						state_q <= ST_RD_F;
					end else if (tile_acc) begin
						cur_x_q <= tx2;
						cur_y_q <= ty2;
						done_q  <= 1'b1;
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RD_F: state_q <= ST_RD_L;
				ST_RD_L: state_q <= ST_DEC;
				ST_DEC:  state_q <= ST_UPD;
				ST_UPD: begin
					if (motion_q == MOT_BACK) begin
						state_q <= ST_RD_B;
					end else begin
						cur_x_q   <= dest_x;
						cur_y_q   <= dest_y;
						heading_q <= hd_dest;
						done_q    <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				ST_RD_B: state_q <= ST_WR_B;
				ST_WR_B: begin
					cur_x_q   <= back_x;
					cur_y_q   <= back_y;
					heading_q <= hd_b;
					done_q    <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_START_X:   cur_x_q   <= START_MOD[cfg_wdata*CW +: CW];
					CFG_START_Y:   cur_y_q   <= START_MOD[cfg_wdata*CW +: CW];
					CFG_START_HDG: heading_q <= cfg_wdata[HEAD_W-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (step_acc) begin
			walls_q <= '{right: cmd.wall_right, front: cmd.wall_front, left: cmd.wall_left};
		end
		if (state_q == ST_RD_F) begin
			cnt_r_q <= rdata;
		end
		if (state_q == ST_RD_L) begin
			cnt_f_q <= rdata;
		end
		if (state_q == ST_DEC) begin
			cnt_l_q  <= rdata;
			motion_q <= motion_d;
		end
		if (tile_acc) begin
			res_q <= '{motion: MOT_NONE, pos_x: POS_W'(tx2), pos_y: POS_W'(ty2),
				heading_out: heading_q};
		end else if (state_q == ST_UPD) begin
			res_q <= '{motion: motion_q, pos_x: POS_W'(dest_x), pos_y: POS_W'(dest_y),
				heading_out: hd_dest};
		end else if (state_q == ST_WR_B) begin
			res_q <= '{motion: MOT_BACK, pos_x: POS_W'(back_x), pos_y: POS_W'(back_y),
				heading_out: hd_b};
		end
	end

	assign done   = done_q;
	assign result = res_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result word outside idle");

	a_we_states: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || state_q == ST_UPD || state_q == ST_WR_B))
		else $error("counter write in a read state");

	a_tile_result: assert property (@(posedge clk) disable iff (!arst_n)
		tile_acc |=> done && result.motion == MOT_NONE)
		else $error("tile report gave no result word");

	a_step_seq: assert property (@(posedge clk) disable iff (!arst_n)
		step_acc |=> state_q == ST_RD_F && !done)
		else $error("step did not start its reads");

endmodule
